// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; clock clk and reset arst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fbpa_pkg.sv =====
// Package for the block pool allocator: sizes, codes and the command word.
package fbpa_pkg;

	localparam int POOL_BLOCKS = 256;
	localparam int IDX_W      = $clog2(POOL_BLOCKS);
	localparam int HEAD_W     = IDX_W + 1;
	localparam int CNT_W      = 9;
	localparam int BYTES_W    = 17;
	localparam int OFF_W      = 24;
	localparam int KIND_W     = 2;
	localparam int ERR_W      = 2;
	localparam int CFG_IDX_W  = 1;

	// Input kind codes
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// Result error codes
	localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
	localparam logic [ERR_W-1:0] ERR_EXHAUSTED = 2'd1;
	localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

	// Classified operation as seen by the back end
	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_FREE,
		OP_CLEAR,
		OP_NOP,
		OP_RANGE_ERR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// Queue head as presented to the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

// ===== rtl/core/fbpa_req_if.sv =====
// Request channel: valid, ready and one request word.
interface fbpa_req_if;
	import fbpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  block_index;

	modport source (output valid, kind, block_index, input ready);
	modport sink (input valid, kind, block_index, output ready);
endinterface

// ===== rtl/core/fbpa_rsp_if.sv =====
// Response channel: valid, ready and one result word.
interface fbpa_rsp_if;
	import fbpa_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] granted_index;
	logic [OFF_W-1:0] granted_offset;
	logic [ERR_W-1:0] error;

	modport source (output valid, granted_index, granted_offset, error, input ready);
	modport sink (input valid, granted_index, granted_offset, error, output ready);
endinterface

// ===== rtl/core/fbpa_front.sv =====
// Front end: accepts request words, classifies them and queues commands.
module fbpa_front (
	input  logic                   clk,
	input  logic                   arst_n,
	fbpa_req_if.sink               req,
	input  logic [fbpa_pkg::HEAD_W-1:0] pool_count,
	output fbpa_pkg::q_head_t      q_head,
	input  logic                   q_pop
);
	import fbpa_pkg::*;

	localparam int Q_DEPTH = 2;

	cmd_t       q_mem_q [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cmd_in;
	logic       push;
	logic       pop;

	// Classify the incoming word; the range check uses the current pool size
	always_comb begin
		cmd_in.idx = req.block_index;
		case (req.kind)
			KIND_ALLOC: cmd_in.op = OP_ALLOC;
			KIND_FREE: begin
				if ({1'b0, req.block_index} >= pool_count)
					cmd_in.op = OP_RANGE_ERR;
				else
					cmd_in.op = OP_FREE;
			end
			KIND_CLEAR: cmd_in.op = OP_CLEAR;
			default: cmd_in.op = OP_NOP;
		endcase
	end

	assign req.ready = (fill_q != 2'(Q_DEPTH));
	assign push      = req.valid && req.ready;
	assign pop       = q_pop && (fill_q != 2'd0);

	// Two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cmd_in;
	end

	assign q_head.valid = (fill_q != 2'd0);
	assign q_head.cmd   = q_mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/fbpa_back.sv =====
// Back end: free list head, link store, valid bits and the result register.
module fbpa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbpa_pkg::q_head_t             q_head,
	output logic                          q_pop,
	input  logic [fbpa_pkg::HEAD_W-1:0]   pool_count,
	input  logic [fbpa_pkg::BYTES_W-1:0]  block_bytes,
	fbpa_rsp_if.source                    rsp
);
	import fbpa_pkg::*;

	localparam int PROD_W = IDX_W + BYTES_W;

	typedef enum logic {
		ST_IDLE,
		ST_LINK
	} state_t;

	state_t                 state_q;
	logic [HEAD_W-1:0]      head_q;
	logic [POOL_BLOCKS-1:0] link_valid_q;
	logic [HEAD_W-1:0]      link_mem [POOL_BLOCKS];
	logic [HEAD_W-1:0]      link_rd_q;
	logic [IDX_W-1:0]       blk_s1;
	logic                   lv_s1;
	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_index_q;
	logic [OFF_W-1:0]       out_offset_q;
	logic [ERR_W-1:0]       out_error_q;
	logic                   slot_free;
	logic                   mem_we;
	logic [PROD_W-1:0]      product;
	logic [IDX_W-1:0]       head_idx;
	logic                   alloc_go;
	logic                   out_load;

	assign slot_free = !out_valid_q || rsp.ready;
	assign q_pop     = q_head.valid && (state_q == ST_IDLE) && slot_free;
	assign mem_we    = q_pop && (q_head.cmd.op == OP_FREE);
	assign head_idx  = head_q[IDX_W-1:0];
	assign product   = PROD_W'(blk_s1) * PROD_W'(block_bytes);

	// Allocate that goes on to the link read; every other popped command answers at once
	assign alloc_go  = q_pop && (q_head.cmd.op == OP_ALLOC) && (head_q < pool_count);
	assign out_load  = (q_pop && !alloc_go) || ((state_q == ST_LINK) && slot_free);

	// Link store: one write port for free, registered read at the head
	always_ff @(posedge clk) begin
		if (mem_we)
			link_mem[q_head.cmd.idx] <= head_q;
		link_rd_q <= link_mem[head_idx];
	end

	// Sequencer, free list head, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			link_valid_q <= '0;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_offset_q <= '0;
			out_error_q  <= ERR_OK;
			blk_s1       <= '0;
			lv_s1        <= 1'b0;
		end else begin
			// Result word held until read out
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_head.cmd.op)
							OP_ALLOC: begin
								if (head_q >= pool_count) begin
									out_index_q  <= '0;
									out_offset_q <= '0;
									out_error_q  <= ERR_EXHAUSTED;
								end else begin
									blk_s1  <= head_idx;
									lv_s1   <= link_valid_q[head_idx];
									state_q <= ST_LINK;
								end
							end
							OP_FREE: begin
								link_valid_q[q_head.cmd.idx] <= 1'b1;
								head_q       <= HEAD_W'(q_head.cmd.idx);
								out_index_q  <= '0;
								out_offset_q <= '0;
								out_error_q  <= ERR_OK;
							end
							OP_CLEAR: begin
								link_valid_q <= '0;
								head_q       <= '0;
								out_index_q  <= '0;
								out_offset_q <= '0;
								out_error_q  <= ERR_OK;
							end
							OP_RANGE_ERR: begin
								out_index_q  <= '0;
								out_offset_q <= '0;
								out_error_q  <= ERR_RANGE;
							end
							default: begin
								out_index_q  <= '0;
								out_offset_q <= '0;
								out_error_q  <= ERR_OK;
							end
						endcase
					end
				end
				ST_LINK: begin
					// Link data for the granted block is now in the read register
					if (slot_free) begin
						head_q       <= lv_s1 ? link_rd_q : HEAD_W'(blk_s1) + HEAD_W'(1);
						out_index_q  <= blk_s1;
						out_offset_q <= product[OFF_W-1:0];
						out_error_q  <= ERR_OK;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.granted_index  = out_index_q;
	assign rsp.granted_offset = out_offset_q;
	assign rsp.error          = out_error_q;

endmodule

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// Top level of the fixed-size block pool allocator.
//
//  channel  dir  handshake        word
//  req      in   valid/ready      kind, block_index
//  rsp      out  valid/ready      granted_index, granted_offset, error
//  cfg      in   cfg_we           cfg_idx, cfg_wdata
//
// A request word is written into the two-entry command queue before the back end takes it.
// Allocate that succeeds passes through ST_IDLE and ST_LINK in the back end (link store
// read, then head update); free, clear and error results are loaded from ST_IDLE.
// The back end takes a command only when the result register is empty or being read
// out that cycle, so a stalled rsp.ready backs up into the queue and then req.ready.
// Reset: asynchronous; head returns to block 0 and all link valid bits clear at once.
module fixed_block_pool_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	fbpa_req_if.sink                          req,
	fbpa_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fbpa_pkg::BYTES_W-1:0]      cfg_wdata
);
	import fbpa_pkg::*;

	`include "assert_macros.svh"

	localparam int CHK_W = IDX_W + BYTES_W;

	logic [CNT_W-1:0]   block_count_q;
	logic [BYTES_W-1:0] block_bytes_q;
	logic [HEAD_W-1:0]  pool_count;
	q_head_t            q_head;
	logic               q_pop;
	logic [CHK_W-1:0]   chk_prod;
	logic               rsp_ok;
	logic               rsp_err;
	logic               grant_fits;
	logic               off_match;
	logic               no_grant;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= CNT_W'(256);
			block_bytes_q <= BYTES_W'(64);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BLOCK_COUNT: block_count_q <= cfg_wdata[CNT_W-1:0];
				REG_BLOCK_BYTES: block_bytes_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Blocks in use, capped at the pool size
	assign pool_count = (block_count_q > CNT_W'(POOL_BLOCKS)) ? HEAD_W'(POOL_BLOCKS)
	                                                           : HEAD_W'(block_count_q);

	fbpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pool_count (pool_count),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	fbpa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.pool_count  (pool_count),
		.block_bytes (block_bytes_q),
		.rsp         (rsp)
	);

	// Terms for the checks
	assign chk_prod   = CHK_W'(rsp.granted_index) * CHK_W'(block_bytes_q);
	assign rsp_ok     = rsp.valid && (rsp.error == ERR_OK);
	assign rsp_err    = rsp.valid && (rsp.error inside {ERR_EXHAUSTED, ERR_RANGE});
	assign grant_fits = (rsp.granted_index == '0) || (HEAD_W'(rsp.granted_index) < pool_count);
	assign off_match  = (rsp.granted_offset == chk_prod[OFF_W-1:0]);
	assign no_grant   = (rsp.granted_index == '0) && (rsp.granted_offset == '0);

	// Checks
	`ASSERT_IMPL(a_grant_in_pool, rsp_ok, grant_fits, "granted block beyond pool")
	`ASSERT_IMPL(a_offset_match, rsp_ok, off_match, "offset does not match index")
	`ASSERT_IMPL(a_error_zero, rsp_err, no_grant, "error word carries a grant")
	`ASSERT_NEXT(a_pop_only_valid, q_pop, $past(q_head.valid), "queue popped while empty")

endmodule
